>>> rtl/amc_pkg.sv
// Shared types, constants and helper functions for the admitted matrix classifier.
package amc_pkg;

	localparam int ROW_W  = 4;
	localparam int N_ROWS = 4;
	localparam int N_SETS = 1 << N_ROWS;
	localparam logic [ROW_W-1:0] ROW_MASK = 4'hF;

	typedef logic [N_SETS-1:1][ROW_W-1:0] amc_img_t;

	typedef struct packed {
		logic [N_ROWS-1:0] strict_ok;
		logic [N_ROWS-1:0] loose_ok;
	} amc_exp_t;

	function automatic logic [2:0] popcount4(input logic [ROW_W-1:0] x);
		logic [2:0] n;
		n = 3'(x[0]) + 3'(x[1]) + 3'(x[2]) + 3'(x[3]);
		return n;
	endfunction

	function automatic logic [ROW_W-1:0] get_row(input logic [N_ROWS*ROW_W-1:0] m,
		input int i);
		logic [ROW_W-1:0] r;
		r = m[i*ROW_W +: ROW_W] & ROW_MASK;
		return r;
	endfunction

endpackage

>>> rtl/admitted_matrix_classifier.sv
// Top level of the admitted matrix classifier: a three-stage pipeline with stream ports.
//
// One 4x4 Boolean matrix enters as a word on the s_axis side: row i sits in
// bits 4i..4i+3 and bit k of a row is column k. For each matrix exactly one
// word leaves on the m_axis side, in input order, carrying two flags.
// The admitted flag is set when all rows are nonzero and some leading level
// passes the strict expansion, the looser expansion at every larger size and
// the column cover check. The scrambling flag is set when every pair of rows
// shares a column.
// Stage one forms the column image of every row set, stage two runs the
// expansion checks at every size, and stage three combines the levels into
// the output register. A word accepted into stage one passes through stage two into
// stage three, which drives m_axis_tvalid; one word per cycle is sustained while
// m_axis_tready stays high. Each stage moves forward whenever the stage after it is
// empty or moving, so a stalled receiver fills the pipeline and only then drops
// s_axis_tready; no word is lost or repeated. Reset clears all valid bits at once.
module admitted_matrix_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] matrix
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [0] admitted, [1] scrambling, [7:2] zero
);
	import amc_pkg::*;

	logic                      vld_s1, vld_s2, vld_s3;
	logic                      rdy_s1, rdy_s2, rdy_s3;
	logic [N_ROWS*ROW_W-1:0]   mat_s1, mat_s2;
	amc_img_t                  img_s1;
	logic                      scr_s1, scr_s2, scr_s3;
	amc_exp_t                  exp_s2;
	logic                      adm_s3;

	amc_img_t                  img_c;
	logic                      scr_c;
	amc_exp_t                  exp_c;
	logic                      adm_c;

	assign rdy_s3 = !vld_s3 || m_axis_tready;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_comb begin
		scr_c = 1'b1;
		img_c = '0;
		for (int p = 1; p < N_SETS; p++) begin
			for (int i = 0; i < N_ROWS; i++) begin
				if (p[i])
					img_c[4'(p)] = img_c[4'(p)] | get_row(s_axis_tdata, i);
			end
		end
		for (int i = 0; i < N_ROWS; i++) begin
			for (int j = i + 1; j < N_ROWS; j++) begin
				if ((get_row(s_axis_tdata, i) & get_row(s_axis_tdata, j)) == '0)
					scr_c = 1'b0;
			end
		end
	end

	amc_expand u_expand (
		.img   (img_s1),
		.flags (exp_c)
	);

	always_comb begin
		logic             pass;
		logic             any_pass;
		logic             all_nz;
		logic [ROW_W-1:0] cols;
		any_pass = 1'b0;
		all_nz   = 1'b1;
		for (int i = 0; i < N_ROWS; i++) begin
			if (get_row(mat_s2, i) == '0)
				all_nz = 1'b0;
		end
		for (int lvl = 1; lvl <= N_ROWS; lvl++) begin
			cols = ROW_W'((1 << lvl) - 1);
			pass = exp_s2.strict_ok[lvl-1];
			for (int s = lvl + 1; s <= N_ROWS; s++) begin
				if (!exp_s2.loose_ok[s-1])
					pass = 1'b0;
			end
			for (int i = lvl; i < N_ROWS; i++) begin
				if ((get_row(mat_s2, i) & cols) == '0)
					pass = 1'b0;
			end
			if (pass)
				any_pass = 1'b1;
		end
		adm_c = all_nz && any_pass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1)
				vld_s1 <= s_axis_tvalid;
			if (rdy_s2)
				vld_s2 <= vld_s1;
			if (rdy_s3)
				vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			mat_s1 <= s_axis_tdata;
			img_s1 <= img_c;
			scr_s1 <= scr_c;
		end
		if (rdy_s2 && vld_s1) begin
			mat_s2 <= mat_s1;
			exp_s2 <= exp_c;
			scr_s2 <= scr_s1;
		end
		if (rdy_s3 && vld_s2) begin
			adm_s3 <= adm_c;
			scr_s3 <= scr_s2;
		end
	end

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tdata  = {6'b0, scr_s3, adm_s3};

endmodule

>>> rtl/amc_expand.sv
// Expansion checks at every leading size from the column images of all row sets.
module amc_expand (
	input  amc_pkg::amc_img_t img,
	output amc_pkg::amc_exp_t flags
);
	import amc_pkg::*;

	always_comb begin
		logic [ROW_W-1:0] cols;
		logic [ROW_W-1:0] ip;
		logic [ROW_W-1:0] iq;
		logic [2:0]       cnt;
		logic [2:0]       need;
		flags = '0;
		for (int s = 1; s <= N_ROWS; s++) begin
			cols = ROW_W'((1 << s) - 1);
			flags.strict_ok[s-1] = 1'b1;
			flags.loose_ok[s-1]  = 1'b1;
			for (int i = 0; i < s; i++) begin
				if ((img[4'(1 << i)] & cols) == '0) begin
					flags.strict_ok[s-1] = 1'b0;
					flags.loose_ok[s-1]  = 1'b0;
				end
			end
			for (int p = 1; p < N_SETS; p++) begin
				for (int q = 1; q < N_SETS; q++) begin
					if (p < (1 << s) && q < (1 << s) && (p & q) == 0) begin
						ip   = img[4'(p)] & cols;
						iq   = img[4'(q)] & cols;
						cnt  = popcount4(ip | iq);
						need = popcount4(4'(p | q));
						if ((ip & iq) == '0) begin
							if (cnt <= need)
								flags.strict_ok[s-1] = 1'b0;
							if (cnt < need)
								flags.loose_ok[s-1] = 1'b0;
						end
					end
				end
			end
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the admitted matrix classifier with its own flag predictor.
module tb;

	typedef struct packed {
		logic scrambling;
		logic admitted;
	} matrix_flags_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;

	logic [15:0]   matrix_q[$];
	matrix_flags_t flags_q[$];
	logic          word_taken = 1'b0;
	int            send_gap_pct = 0;
	int            recv_stall_pct = 0;
	int            mismatches = 0;

	always #6 clk = ~clk;

	admitted_matrix_classifier u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	function automatic int ones4(logic [3:0] x);
		return int'(x[0]) + int'(x[1]) + int'(x[2]) + int'(x[3]);
	endfunction

	function automatic logic [3:0] row_set_image(logic [15:0] m, int rows, logic [3:0] cols);
		logic [3:0] img;
		img = '0;
		for (int i = 0; i < 4; i++)
			if (((rows >> i) & 1) != 0)
				img |= m[4*i +: 4] & cols;
		return img;
	endfunction

	// Hall-type expansion over the leading rows and columns of the given size.
	function automatic bit hall_expands(logic [15:0] m, int size, bit strict);
		logic [3:0] cols;
		logic [3:0] img_p;
		logic [3:0] img_q;
		cols = 4'((1 << size) - 1);
		for (int i = 0; i < size; i++)
			if ((m[4*i +: 4] & cols) == 4'd0)
				return 1'b0;
		for (int p = 1; p < (1 << size); p++) begin
			img_p = row_set_image(m, p, cols);
			for (int q = 1; q < (1 << size); q++) begin
				if ((p & q) != 0)
					continue;
				img_q = row_set_image(m, q, cols);
				if ((img_p & img_q) != 4'd0)
					continue;
				if (ones4(img_p | img_q) < ones4(4'(p | q)) + int'(strict))
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic bit level_admits(logic [15:0] m, int level);
		logic [3:0] cols;
		cols = 4'((1 << level) - 1);
		if (!hall_expands(m, level, 1'b1))
			return 1'b0;
		for (int s = level + 1; s <= 4; s++)
			if (!hall_expands(m, s, 1'b0))
				return 1'b0;
		for (int i = level; i < 4; i++)
			if ((m[4*i +: 4] & cols) == 4'd0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic matrix_flags_t classify_matrix(logic [15:0] m);
		matrix_flags_t f;
		bit            rows_nonzero;
		rows_nonzero = 1'b1;
		for (int i = 0; i < 4; i++)
			if (m[4*i +: 4] == 4'd0)
				rows_nonzero = 1'b0;
		f.admitted = 1'b0;
		if (rows_nonzero)
			for (int level = 1; level <= 4; level++)
				if (level_admits(m, level))
					f.admitted = 1'b1;
		f.scrambling = 1'b1;
		for (int i = 0; i < 4; i++)
			for (int j = i + 1; j < 4; j++)
				if ((m[4*i +: 4] & m[4*j +: 4]) == 4'd0)
					f.scrambling = 1'b0;
		return f;
	endfunction

	// A quarter of the matrices are raw noise; the rest have no zero row and a
	// random density, which is where both flags actually vary.
	function automatic logic [15:0] random_matrix();
		logic [15:0] m;
		int          density;
		if ($urandom_range(3) == 0)
			return 16'($urandom);
		density = $urandom_range(95, 30);
		for (int b = 0; b < 16; b++)
			m[b] = ($urandom_range(99) < density);
		for (int i = 0; i < 4; i++)
			if (m[4*i +: 4] == 4'd0)
				m[4*i + $urandom_range(3)] = 1'b1;
		return m;
	endfunction

	task automatic note_mismatch(string what, logic [7:0] want, logic [7:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%t mismatch (%s): expected %02h, got %02h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin : check_output
		matrix_flags_t want;
		word_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			flags_q = {flags_q, classify_matrix(s_axis_tdata)};
		if (m_axis_tvalid && m_axis_tready) begin
			if (flags_q.size() == 0) begin
				note_mismatch("unexpected word", 8'h00, m_axis_tdata);
			end else begin
				want = flags_q.pop_front();
				if (m_axis_tdata[0] !== want.admitted)
					note_mismatch("admitted", {6'd0, want}, m_axis_tdata);
				if (m_axis_tdata[1] !== want.scrambling)
					note_mismatch("scrambling", {6'd0, want}, m_axis_tdata);
				if (m_axis_tdata[7:2] !== 6'd0)
					note_mismatch("padding", {6'd0, want}, m_axis_tdata);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || word_taken)) begin
			if (matrix_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				s_axis_tdata  <= matrix_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		logic [15:0] directed[$] = '{
			16'h0000, 16'hFFFF, 16'h8421, 16'h1248, 16'h0FFF, 16'hFFF0,
			16'hFFF1, 16'hF731, 16'h8CEF, 16'h1111, 16'h5555, 16'hAAAA,
			16'h3333, 16'hCCCC, 16'h7777, 16'hEEEE, 16'hBDE7, 16'h0001,
			16'h8000, 16'h137F, 16'h2184, 16'h9F6F
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			@(posedge clk);
			case (phase)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 54;
				end
				default: begin
					send_gap_pct = 12;
					recv_stall_pct = 12;
				end
			endcase
			if (phase == 0)
				foreach (directed[k])
					matrix_q = {matrix_q, directed[k]};
			repeat (300)
				matrix_q = {matrix_q, random_matrix()};
			while (matrix_q.size() != 0 || s_axis_tvalid || flags_q.size() != 0)
				@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
